### sv/vono_pkg.sv
// shared types and constants for the voxel occupancy and nearest obstacle block
`default_nettype none
package vono_pkg;
	localparam int GRID_X_DEF = 128;
	localparam int GRID_Y_DEF = 128;
	localparam int GRID_Z_DEF = 16;

	localparam int COORD_W = 18;
	localparam int SIZE_W  = 16;
	localparam int IDX_W   = 20;
	localparam int SQ_W    = 36;
	localparam int CNT_W   = 19;

	localparam logic [2:0] REG_FORWARD_IS_Y = 3'd0;
	localparam logic [2:0] REG_MIN_HEIGHT   = 3'd1;
	localparam logic [2:0] REG_MAX_HEIGHT   = 3'd2;
	localparam logic [2:0] REG_EGO_BOX      = 3'd3;
	localparam logic [2:0] REG_ROI_BOX      = 3'd4;
	localparam logic [2:0] REG_VOXEL_SIZE   = 3'd5;

	typedef struct packed {
		logic                      start;
		logic signed [COORD_W-1:0] dividend;
		logic [SIZE_W-1:0]         divisor;
	} div_req_t;

	typedef struct packed {
		logic                    done;
		logic signed [IDX_W-1:0] quot;
	} div_rsp_t;
endpackage
`default_nettype wire

### sv/vono_div.sv
// bit-serial signed floor divider, one quotient bit per cycle
`default_nettype none
module vono_div (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire vono_pkg::div_req_t req,
	output vono_pkg::div_rsp_t    rsp
);
	logic                              busy_q;
	logic                              done_q;
	logic                              neg_q;
	logic [4:0]                        cnt_q;
	logic [vono_pkg::COORD_W-1:0]      mag_q;
	logic [vono_pkg::SIZE_W-1:0]       rem_q;
	logic [vono_pkg::SIZE_W-1:0]       dvs_q;
	logic [vono_pkg::SIZE_W:0]         trial;
	logic [vono_pkg::SIZE_W:0]         diff;
	logic                              qbit;
	logic signed [vono_pkg::IDX_W-1:0] q_ext;

	assign trial = {rem_q, mag_q[vono_pkg::COORD_W-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign qbit  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'(vono_pkg::COORD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			neg_q <= req.dividend[vono_pkg::COORD_W-1];
			mag_q <= req.dividend[vono_pkg::COORD_W-1] ? 18'(-req.dividend) : req.dividend;
			rem_q <= '0;
			dvs_q <= (req.divisor == '0) ? 16'd1 : req.divisor;
		end else if (busy_q) begin
			mag_q <= {mag_q[vono_pkg::COORD_W-2:0], qbit};
			rem_q <= qbit ? diff[vono_pkg::SIZE_W-1:0] : trial[vono_pkg::SIZE_W-1:0];
		end
	end

	assign q_ext    = $signed({2'b00, mag_q});
	assign rsp.done = done_q;
	assign rsp.quot = neg_q ? (-q_ext - ((rem_q != '0) ? 20'sd1 : 20'sd0)) : q_ext;
endmodule
`default_nettype wire

### sv/vono_sqrt.sv
// digit-serial integer square root, one root bit per cycle
`default_nettype none
module vono_sqrt (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	input  wire logic [vono_pkg::SQ_W-1:0] value,
	output logic                           done,
	output logic [vono_pkg::COORD_W-1:0]   root
);
	logic                           busy_q;
	logic                           done_q;
	logic [4:0]                     cnt_q;
	logic [vono_pkg::SQ_W-1:0]      rad_q;
	logic [19:0]                    rem_q;
	logic [vono_pkg::COORD_W-1:0]   root_q;
	logic [21:0]                    cat;
	logic [21:0]                    trial;
	logic                           take;

	assign cat   = {rem_q, rad_q[vono_pkg::SQ_W-1:vono_pkg::SQ_W-2]};
	assign trial = {2'b00, root_q, 2'b01};
	assign take  = cat >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'(vono_pkg::COORD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= value;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q  <= {rad_q[vono_pkg::SQ_W-3:0], 2'b00};
			rem_q  <= take ? 20'(cat - trial) : cat[19:0];
			root_q <= {root_q[vono_pkg::COORD_W-2:0], take};
		end
	end

	assign done = done_q;
	assign root = root_q;
endmodule
`default_nettype wire

### sv/vono_grid.sv
// occupancy bit memory, 32-bit words, registered read
`default_nettype none
module vono_grid #(
	parameter int WORDS = 8192,
	parameter int WAW   = 13
) (
	input  wire logic           clk,
	input  wire logic [WAW-1:0] addr,
	input  wire logic           wr_en,
	input  wire logic [31:0]    wr_data,
	output logic [31:0]         rd_data
);
	logic [31:0] mem [WORDS];

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[addr] <= wr_data;
		rd_data <= mem[addr];
	end
endmodule
`default_nettype wire

### sv/voxel_occupancy_nearest_obstacle.sv
// top level: point filter, serial voxel mapping, occupancy count and nearest search
//
// points arrive on the s_ stream, one request per point; results leave on the m_ stream.
// a point is taken only while the block is idle. a dropped point ends in the check
// state; a kept point runs the divide, address, read, update and compare states and
// ends early outside the grid or on an occupied cell. the three floor divisions share
// one bit-serial divider. a point marked tlast then runs the serial square root and
// waits in emit until the output register is free; then the result is loaded into it
// and the grid is cleared, one 32-bit word per cycle (GRID_X*GRID_Y*GRID_Z/32 words,
// 8192 by default) before the next point is taken.
// after reset the same clearing sweep runs first; s_tready stays low during it.
// configuration writes over the apb port belong between frames, with no point in flight.
// if the receiver stalls, the result waits in the output register; a following frame
// may proceed and only blocks when its own result is ready while the previous one waits.
`default_nettype none
module voxel_occupancy_nearest_obstacle #(
	parameter int GRID_X = vono_pkg::GRID_X_DEF,
	parameter int GRID_Y = vono_pkg::GRID_Y_DEF,
	parameter int GRID_Z = vono_pkg::GRID_Z_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [5:0]  paddr,
	input  wire logic [63:0] pwdata,
	output logic [63:0]      prdata,
	output logic             pready,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [55:0] s_tdata,  // x_mm, y_mm, z_mm, zero pad
	input  wire logic        s_tlast,
	input  wire logic        s_tuser,  // finite
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [79:0]      m_tdata,  // occupied_count, nearest_distance_mm,
	                                   // nearest_forward_mm, nearest_lateral_mm, zero pad
	output logic [1:0]       m_tuser   // nearest_found, grid_overflow
);
	localparam int CELLS = GRID_X * GRID_Y * GRID_Z;
	localparam int WORDS = (CELLS + 31) / 32;
	localparam int WAW   = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int CAW0  = $clog2(CELLS);
	localparam int CAW   = (CAW0 < 6) ? 6 : CAW0;

	localparam logic signed [vono_pkg::IDX_W-1:0] IDX_W_GX = vono_pkg::IDX_W'(GRID_X);
	localparam logic signed [vono_pkg::IDX_W-1:0] IDX_W_GY = vono_pkg::IDX_W'(GRID_Y);
	localparam logic signed [vono_pkg::IDX_W-1:0] IDX_W_GZ = vono_pkg::IDX_W'(GRID_Z);

	typedef enum logic [10:0] {
		ST_CLEAR  = 11'b00000000001,
		ST_IDLE   = 11'b00000000010,
		ST_CHECK  = 11'b00000000100,
		ST_DIV    = 11'b00000001000,
		ST_ADDR   = 11'b00000010000,
		ST_READ   = 11'b00000100000,
		ST_UPDATE = 11'b00001000000,
		ST_SQ_L   = 11'b00010000000,
		ST_CMP    = 11'b00100000000,
		ST_SQRT   = 11'b01000000000,
		ST_EMIT   = 11'b10000000000
	} state_t;

	state_t state_q;

	logic                                fwd_y_q;
	logic signed [vono_pkg::COORD_W-1:0] min_h_q;
	logic signed [vono_pkg::COORD_W-1:0] max_h_q;
	logic [53:0]                         ego_q;
	logic [53:0]                         roi_q;
	logic [47:0]                         vsz_q;

	logic signed [vono_pkg::COORD_W-1:0] x_q, y_q, z_q;
	logic                                finite_q, last_q;
	logic [1:0]                          axis_q;
	logic signed [vono_pkg::IDX_W-1:0]   ix_q, iy_q, iz_q;
	logic [CAW-1:0]                      addr_q;
	logic [vono_pkg::SQ_W-1:0]           sq_q;
	logic [WAW-1:0]                      clr_q;

	logic [vono_pkg::CNT_W-1:0]          total_q;
	logic [vono_pkg::SQ_W-1:0]           best_sq_q;
	logic signed [vono_pkg::COORD_W-1:0] best_f_q, best_l_q;
	logic                                found_q, ovf_q;

	logic                                m_valid_q;
	logic [79:0]                         m_data_q;
	logic [1:0]                          m_user_q;

	logic                                cfg_wr;
	logic signed [vono_pkg::COORD_W-1:0] fwd, lat;
	logic signed [vono_pkg::COORD_W:0]   fwd_e;
	logic [vono_pkg::COORD_W:0]          alat;
	logic                                keep;
	logic                                in_ego, out_roi, in_band;
	logic                                in_grid;
	vono_pkg::div_req_t                  div_req;
	vono_pkg::div_rsp_t                  div_rsp;
	logic                                sqrt_start, sqrt_done;
	logic [vono_pkg::SQ_W-1:0]           sqrt_val;
	logic [vono_pkg::COORD_W-1:0]        sqrt_root;
	logic [WAW-1:0]                      mem_addr;
	logic                                mem_we;
	logic [31:0]                         mem_wd, mem_rd;
	logic                                hit;
	logic signed [vono_pkg::COORD_W-1:0] mul_a;
	logic signed [35:0]                  mul_p;
	logic                                point_end;
	logic                                m_free;

	// configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_y_q <= 1'b0;
			min_h_q <= -18'sd131072;
			max_h_q <= 18'sd131071;
			ego_q   <= '0;
			roi_q   <= '1;
			vsz_q   <= 48'd859006566600;
		end else if (cfg_wr) begin
			unique case (paddr[5:3])
				vono_pkg::REG_FORWARD_IS_Y: fwd_y_q <= pwdata[0];
				vono_pkg::REG_MIN_HEIGHT:   min_h_q <= pwdata[17:0];
				vono_pkg::REG_MAX_HEIGHT:   max_h_q <= pwdata[17:0];
				vono_pkg::REG_EGO_BOX:      ego_q   <= pwdata[53:0];
				vono_pkg::REG_ROI_BOX:      roi_q   <= pwdata[53:0];
				vono_pkg::REG_VOXEL_SIZE:   vsz_q   <= pwdata[47:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[5:3])
			vono_pkg::REG_FORWARD_IS_Y: prdata = {63'd0, fwd_y_q};
			vono_pkg::REG_MIN_HEIGHT:   prdata = {46'd0, min_h_q};
			vono_pkg::REG_MAX_HEIGHT:   prdata = {46'd0, max_h_q};
			vono_pkg::REG_EGO_BOX:      prdata = {10'd0, ego_q};
			vono_pkg::REG_ROI_BOX:      prdata = {10'd0, roi_q};
			vono_pkg::REG_VOXEL_SIZE:   prdata = {16'd0, vsz_q};
			default:                    prdata = '0;
		endcase
	end

	// point filter
	assign fwd   = fwd_y_q ? y_q : x_q;
	assign lat   = fwd_y_q ? x_q : y_q;
	assign fwd_e = 19'(fwd);
	assign alat  = lat[vono_pkg::COORD_W-1] ? 19'(-20'(lat)) : 19'(lat);
	assign in_band = (z_q >= min_h_q) && (z_q <= max_h_q);
	assign in_ego  = (fwd_e <= $signed({1'b0, ego_q[53:36]}))
		&& (fwd_e >= -$signed({1'b0, ego_q[35:18]}))
		&& (alat <= {1'b0, ego_q[17:0]});
	assign out_roi = (fwd_e > $signed({1'b0, roi_q[53:36]}))
		|| (fwd_e < -$signed({1'b0, roi_q[35:18]}))
		|| (alat > {1'b0, roi_q[17:0]});
	assign keep = finite_q & in_band & ~in_ego & ~out_roi;

	// serial divider, one axis after another
	always_comb begin
		div_req.start    = 1'b0;
		div_req.dividend = x_q;
		div_req.divisor  = vsz_q[47:32];
		if (state_q == ST_CHECK) begin
			div_req.start = keep;
		end else if (state_q == ST_DIV && div_rsp.done && axis_q != 2'd2) begin
			div_req.start = 1'b1;
			if (axis_q == 2'd0) begin
				div_req.dividend = y_q;
				div_req.divisor  = vsz_q[31:16];
			end else begin
				div_req.dividend = z_q;
				div_req.divisor  = vsz_q[15:0];
			end
		end
	end

	vono_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign in_grid = (ix_q >= 0) && (ix_q < IDX_W_GX) && (iy_q >= 0) && (iy_q < IDX_W_GY)
		&& (iz_q >= 0) && (iz_q < IDX_W_GZ);

	// occupancy memory
	assign hit      = mem_rd[addr_q[4:0]];
	assign mem_addr = (state_q == ST_CLEAR) ? clr_q : WAW'(addr_q >> 5);
	assign mem_we   = (state_q == ST_CLEAR) || (state_q == ST_UPDATE && !hit);
	assign mem_wd   = (state_q == ST_CLEAR) ? 32'd0 : (mem_rd | (32'd1 << addr_q[4:0]));

	vono_grid #(
		.WORDS (WORDS),
		.WAW   (WAW)
	) u_grid (
		.clk     (clk),
		.addr    (mem_addr),
		.wr_en   (mem_we),
		.wr_data (mem_wd),
		.rd_data (mem_rd)
	);

	// one shared 18 by 18 multiplier for the squares
	assign mul_a = (state_q == ST_UPDATE) ? fwd : lat;
	assign mul_p = mul_a * mul_a;

	// the compare of the last point feeds the root directly
	assign sqrt_start = point_end && last_q;
	assign sqrt_val   = (state_q == ST_CMP && sq_q < best_sq_q) ? sq_q : best_sq_q;

	vono_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sqrt_start),
		.value  (sqrt_val),
		.done   (sqrt_done),
		.root   (sqrt_root)
	);

	always_comb begin
		point_end = 1'b0;
		unique case (state_q)
			ST_CHECK:  point_end = !keep;
			ST_ADDR:   point_end = !in_grid;
			ST_UPDATE: point_end = hit;
			ST_CMP:    point_end = 1'b1;
			default:   point_end = 1'b0;
		endcase
	end

	assign m_free   = !m_valid_q || m_tready;
	assign s_tready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (state_q == ST_EMIT && m_free) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_q     <= '0;
			axis_q    <= '0;
			total_q   <= '0;
			best_sq_q <= '1;
			best_f_q  <= '0;
			best_l_q  <= '0;
			found_q   <= 1'b0;
			ovf_q     <= 1'b0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == WAW'(WORDS - 1))
						state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (s_tvalid)
						state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					axis_q <= '0;
					if (keep)
						state_q <= ST_DIV;
					else
						state_q <= last_q ? ST_SQRT : ST_IDLE;
				end
				ST_DIV: begin
					if (div_rsp.done) begin
						axis_q <= axis_q + 2'd1;
						if (axis_q == 2'd2)
							state_q <= ST_ADDR;
					end
				end
				ST_ADDR: begin
					if (!in_grid) begin
						ovf_q   <= 1'b1;
						state_q <= last_q ? ST_SQRT : ST_IDLE;
					end else begin
						state_q <= ST_READ;
					end
				end
				ST_READ: state_q <= ST_UPDATE;
				ST_UPDATE: begin
					if (hit) begin
						state_q <= last_q ? ST_SQRT : ST_IDLE;
					end else begin
						total_q <= total_q + 1'b1;
						found_q <= 1'b1;
						state_q <= ST_SQ_L;
					end
				end
				ST_SQ_L: state_q <= ST_CMP;
				ST_CMP: begin
					if (sq_q < best_sq_q) begin
						best_sq_q <= sq_q;
						best_f_q  <= fwd;
						best_l_q  <= lat;
					end
					state_q <= last_q ? ST_SQRT : ST_IDLE;
				end
				ST_SQRT: begin
					if (sqrt_done)
						state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (m_free) begin
						total_q   <= '0;
						best_sq_q <= '1;
						best_f_q  <= '0;
						best_l_q  <= '0;
						found_q   <= 1'b0;
						ovf_q     <= 1'b0;
						clr_q     <= '0;
						state_q   <= ST_CLEAR;
					end
				end
				default: state_q <= ST_CLEAR;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && s_tvalid) begin
			x_q      <= s_tdata[17:0];
			y_q      <= s_tdata[35:18];
			z_q      <= s_tdata[53:36];
			finite_q <= s_tuser;
			last_q   <= s_tlast;
		end
		if (state_q == ST_DIV && div_rsp.done) begin
			if (axis_q == 2'd0)
				ix_q <= div_rsp.quot + vono_pkg::IDX_W'(GRID_X / 2);
			else if (axis_q == 2'd1)
				iy_q <= div_rsp.quot + vono_pkg::IDX_W'(GRID_Y / 2);
			else
				iz_q <= div_rsp.quot + vono_pkg::IDX_W'(GRID_Z / 2);
		end
		if (state_q == ST_ADDR)
			addr_q <= CAW'((ix_q * GRID_Y + iy_q) * GRID_Z + iz_q);
		if (state_q == ST_UPDATE)
			sq_q <= mul_p;
		if (state_q == ST_SQ_L)
			sq_q <= sq_q + mul_p;
		if (state_q == ST_EMIT && m_free) begin
			m_data_q <= {7'd0, best_l_q, best_f_q, sqrt_root, total_q};
			m_user_q <= {ovf_q, found_q};
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;
	assign m_tuser  = m_user_q;
endmodule
`default_nettype wire

### tb/sv/tb_voxel_occupancy_nearest_obstacle.sv
// self-checking testbench for the voxel occupancy and nearest obstacle block
`default_nettype none
module tb_voxel_occupancy_nearest_obstacle;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int GX = vono_pkg::GRID_X_DEF;
	localparam int GY = vono_pkg::GRID_Y_DEF;
	localparam int GZ = vono_pkg::GRID_Z_DEF;
	localparam int CELL_COUNT = GX * GY * GZ;
	localparam longint CYCLE_LIMIT = 64'd60000000;

	typedef struct packed {
		logic [18:0]        count;
		logic [17:0]        distance;
		logic signed [17:0] fwd;
		logic signed [17:0] lat;
		logic               found;
		logic               ovf;
	} frame_result_t;

	typedef struct {
		logic signed [17:0] x;
		logic signed [17:0] y;
		logic signed [17:0] z;
		logic               fin;
		logic               last;
		logic               typed;
		frame_result_t      res;
	} point_row_t;

	logic        clk, arst_n;
	logic        psel, penable, pwrite;
	logic [5:0]  paddr;
	logic [63:0] pwdata, prdata;
	logic        pready;
	logic        s_tvalid, s_tready, s_tlast, s_tuser;
	logic [55:0] s_tdata;
	logic        m_tvalid, m_tready;
	logic [79:0] m_tdata;
	logic [1:0]  m_tuser;

	voxel_occupancy_nearest_obstacle u_dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.s_tlast(s_tlast), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	// predictor copy of configuration and frame state
	logic               cfg_fwd_y;
	logic signed [17:0] cfg_zmin, cfg_zmax;
	logic [53:0]        cfg_ego, cfg_roi;
	logic [47:0]        cfg_vox;
	bit                 occ_map [CELL_COUNT];
	int unsigned        occ_total;
	logic [35:0]        best_sq;
	logic signed [17:0] best_fwd, best_lat;
	bit                 any_found, any_ovf;

	frame_result_t frame_results_due[$];
	int            fail_count;
	longint        cycle_count;
	bit            idle_on;
	int            stall_left;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	function automatic longint floor_quot(longint a, longint b);
		longint q;
		q = a / b;
		if ((a % b) != 0 && a < 0)
			q = q - 1;
		return q;
	endfunction

	function automatic longint size_of(int sh);
		longint s;
		s = longint'((cfg_vox >> sh) & 48'hFFFF);
		return s == 0 ? 1 : s;
	endfunction

	function automatic logic [35:0] floor_root_try(logic [35:0] r, int b, logic [35:0] v);
		logic [35:0] t;
		if (b == 17)
			r = '0;
		t = r | (36'd1 << b);
		return (t * t <= v) ? t : r;
	endfunction

	function automatic logic [17:0] floor_root(logic [35:0] v);
		logic [35:0] r;
		for (int b = 17; b >= 0; b--) begin
			r = floor_root_try(r, b, v);
		end
		return r[17:0];
	endfunction

	task automatic clear_frame_state();
		for (int i = 0; i < CELL_COUNT; i++)
			occ_map[i] = 1'b0;
		occ_total = 0;
		best_sq = '1;
		best_fwd = '0;
		best_lat = '0;
		any_found = 1'b0;
		any_ovf = 1'b0;
	endtask

	task automatic predict_point(logic signed [17:0] x, logic signed [17:0] y,
			logic signed [17:0] z, logic fin, logic last, output bit emits,
			output frame_result_t r);
		longint fw, lt, alt, ix, iy, iz, sq;
		int addr;
		emits = 1'b0;
		r = '0;
		if (fin && z >= cfg_zmin && z <= cfg_zmax) begin
			fw = cfg_fwd_y ? longint'(y) : longint'(x);
			lt = cfg_fwd_y ? longint'(x) : longint'(y);
			alt = lt < 0 ? -lt : lt;
			if (!(fw <= longint'(cfg_ego[53:36]) && fw >= -longint'(cfg_ego[35:18])
					&& alt <= longint'(cfg_ego[17:0])) &&
				!(fw > longint'(cfg_roi[53:36]) || fw < -longint'(cfg_roi[35:18])
					|| alt > longint'(cfg_roi[17:0]))) begin
				ix = floor_quot(x, size_of(32)) + GX / 2;
				iy = floor_quot(y, size_of(16)) + GY / 2;
				iz = floor_quot(z, size_of(0)) + GZ / 2;
				if (ix < 0 || ix >= GX || iy < 0 || iy >= GY || iz < 0 || iz >= GZ) begin
					any_ovf = 1'b1;
				end else begin
					addr = int'((ix * GY + iy) * GZ + iz);
					if (!occ_map[addr]) begin
						occ_map[addr] = 1'b1;
						occ_total++;
						any_found = 1'b1;
						sq = fw * fw + lt * lt;
						if (sq < longint'(best_sq)) begin
							best_sq = sq[35:0];
							best_fwd = fw[17:0];
							best_lat = lt[17:0];
						end
					end
				end
			end
		end
		if (last) begin
			emits = 1'b1;
			r.count = occ_total[18:0];
			r.distance = any_found ? floor_root(best_sq) : 18'h3FFFF;
			r.fwd = any_found ? best_fwd : '0;
			r.lat = any_found ? best_lat : '0;
			r.found = any_found;
			r.ovf = any_ovf;
			clear_frame_state();
		end
	endtask

	task automatic apb_write(logic [2:0] idx, logic [63:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 3'b000};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			vono_pkg::REG_FORWARD_IS_Y: cfg_fwd_y = val[0];
			vono_pkg::REG_MIN_HEIGHT:   cfg_zmin = val[17:0];
			vono_pkg::REG_MAX_HEIGHT:   cfg_zmax = val[17:0];
			vono_pkg::REG_EGO_BOX:      cfg_ego = val[53:0];
			vono_pkg::REG_ROI_BOX:      cfg_roi = val[53:0];
			vono_pkg::REG_VOXEL_SIZE:   cfg_vox = val[47:0];
			default: ;
		endcase
	endtask

	task automatic set_config(logic fy, logic signed [17:0] zlo, logic signed [17:0] zhi,
			logic [53:0] ego, logic [53:0] roi, logic [47:0] vox);
		apb_write(vono_pkg::REG_FORWARD_IS_Y, {63'd0, fy});
		apb_write(vono_pkg::REG_MIN_HEIGHT, {{46{zlo[17]}}, zlo});
		apb_write(vono_pkg::REG_MAX_HEIGHT, {{46{zhi[17]}}, zhi});
		apb_write(vono_pkg::REG_EGO_BOX, {10'd0, ego});
		apb_write(vono_pkg::REG_ROI_BOX, {10'd0, roi});
		apb_write(vono_pkg::REG_VOXEL_SIZE, {16'd0, vox});
	endtask

	// s_tvalid stays high after acceptance until the next request or an idle burst
	task automatic drive_point(logic signed [17:0] x, logic signed [17:0] y,
			logic signed [17:0] z, logic fin, logic last);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {2'b00, z, y, x};
		s_tlast <= last;
		s_tuser <= fin;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic send_point(logic signed [17:0] x, logic signed [17:0] y,
			logic signed [17:0] z, logic fin, logic last);
		bit emits;
		frame_result_t r;
		drive_point(x, y, z, fin, last);
		predict_point(x, y, z, fin, last, emits, r);
		if (emits)
			frame_results_due.push_back(r);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (frame_results_due.size() != 0)
			@(posedge clk);
		// the grid sweep after a frame must finish before registers change
		repeat (8400) @(posedge clk);
	endtask

	// receiver side
	always @(posedge clk) begin
		if (m_tready) begin
			if (idle_on && $urandom_range(0, 5) == 0) begin
				m_tready <= 1'b0;
				stall_left <= $urandom_range(0, 3);
			end
		end else if (stall_left == 0) begin
			m_tready <= 1'b1;
		end else begin
			stall_left <= stall_left - 1;
		end
	end

	always @(posedge clk) begin
		frame_result_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got.count = m_tdata[18:0];
			got.distance = m_tdata[36:19];
			got.fwd = m_tdata[54:37];
			got.lat = m_tdata[72:55];
			got.found = m_tuser[0];
			got.ovf = m_tuser[1];
			if (frame_results_due.size() == 0) begin
				$error("unexpected result count=%0d", got.count);
				fail_count++;
			end else begin
				want = frame_results_due.pop_front();
				if (got.count !== want.count) begin
					$error("occupied_count exp %0d got %0d", want.count, got.count);
					fail_count++;
				end
				if (got.distance !== want.distance) begin
					$error("nearest_distance_mm exp %0d got %0d", want.distance,
						got.distance);
					fail_count++;
				end
				if (got.fwd !== want.fwd) begin
					$error("nearest_forward_mm exp %0d got %0d", want.fwd, got.fwd);
					fail_count++;
				end
				if (got.lat !== want.lat) begin
					$error("nearest_lateral_mm exp %0d got %0d", want.lat, got.lat);
					fail_count++;
				end
				if (got.found !== want.found) begin
					$error("nearest_found exp %0b got %0b", want.found, got.found);
					fail_count++;
				end
				if (got.ovf !== want.ovf) begin
					$error("grid_overflow exp %0b got %0b", want.ovf, got.ovf);
					fail_count++;
				end
			end
		end
	end

	function automatic logic signed [17:0] rand_coord(int span);
		int v;
		if ($urandom_range(0, 19) == 0)
			return 18'($urandom);
		v = $urandom_range(0, 2 * span) - span;
		return 18'(v);
	endfunction

	point_row_t directed_rows[$];

	task automatic add_row(int x, int y, int z, logic fin, logic last, bit typed,
			frame_result_t r);
		point_row_t p;
		p.x = 18'(x);
		p.y = 18'(y);
		p.z = 18'(z);
		p.fin = fin;
		p.last = last;
		p.typed = typed;
		p.res = r;
		directed_rows.push_back(p);
	endtask

	initial begin
		frame_result_t empty_res, none;
		frame_result_t got_r;
		bit emits;
		int n_items;
		int frame_len;
		int span;

		arst_n = 1'b0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		s_tvalid = 1'b0; s_tdata = '0; s_tlast = 1'b0; s_tuser = 1'b0;
		m_tready = 1'b1;
		stall_left = 0;
		fail_count = 0;
		cycle_count = 0;
		idle_on = 1'b1;
		cfg_fwd_y = 1'b0;
		cfg_zmin = -18'sd131072;
		cfg_zmax = 18'sd131071;
		cfg_ego = '0;
		cfg_roi = '1;
		cfg_vox = 48'd859006566600;
		clear_frame_state();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		empty_res = '{count: 0, distance: 18'h3FFFF, fwd: 0, lat: 0, found: 0, ovf: 0};
		none = '0;
		// empty frame, dropped last point, extremes and overflow under reset config
		add_row(0, 0, 0, 1'b0, 1'b1, 1'b1, empty_res);
		add_row(1000, -500, 0, 1'b1, 1'b0, 1'b0, none);
		add_row(1100, -450, 10, 1'b1, 1'b0, 1'b0, none);
		add_row(-3000, 4000, -100, 1'b1, 1'b1, 1'b0, none);
		add_row(131071, 131071, 131071, 1'b1, 1'b0, 1'b0, none);
		add_row(-131072, -131072, -131072, 1'b1, 1'b1, 1'b1,
			'{count: 0, distance: 18'h3FFFF, fwd: 0, lat: 0, found: 0, ovf: 1});
		// the origin lies on the empty ego box and is dropped
		add_row(0, 0, 0, 1'b1, 1'b1, 1'b1, empty_res);
		add_row(-1, -1, -1, 1'b1, 1'b0, 1'b0, none);
		add_row(12799, -12800, 1599, 1'b1, 1'b0, 1'b0, none);
		add_row(-12801, 12800, -1601, 1'b1, 1'b0, 1'b0, none);
		add_row(500, 700, 0, 1'b0, 1'b1, 1'b0, none);

		foreach (directed_rows[i]) begin
			if (directed_rows[i].typed) begin
				predict_point(directed_rows[i].x, directed_rows[i].y, directed_rows[i].z,
					directed_rows[i].fin, 1'b0, emits, got_r);
				clear_frame_state();
				frame_results_due.push_back(directed_rows[i].res);
				drive_point(directed_rows[i].x, directed_rows[i].y, directed_rows[i].z,
					directed_rows[i].fin, 1'b1);
			end else begin
				send_point(directed_rows[i].x, directed_rows[i].y, directed_rows[i].z,
					directed_rows[i].fin, directed_rows[i].last);
			end
		end
		drain();

		// inverted height band, forward from y, tight boxes, zero sizes
		set_config(1'b1, 18'sd500, -18'sd500, {18'd100, 18'd100, 18'd100},
			{18'd5000, 18'd5000, 18'd5000}, {16'd0, 16'd0, 16'd0});
		send_point(10, 20, 0, 1'b1, 1'b0);
		send_point(300, 400, 0, 1'b1, 1'b1);
		drain();
		set_config(1'b1, -18'sd100, 18'sd100, {18'd1000, 18'd2000, 18'd500},
			{18'd8000, 18'd6000, 18'd4000}, {16'd100, 16'd150, 16'd20});
		send_point(500, 1000, 0, 1'b1, 1'b0);
		send_point(501, 1001, 0, 1'b1, 1'b0);
		send_point(4000, 8000, 100, 1'b1, 1'b0);
		send_point(-4000, -6000, -100, 1'b1, 1'b0);
		send_point(0, 8001, 0, 1'b1, 1'b0);
		send_point(-600, -300, 50, 1'b1, 1'b1);
		drain();

		// random phases over several settings
		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: set_config(1'b0, -18'sd131072, 18'sd131071, '0, '1,
					48'd859006566600);
				7: set_config(1'b1, -18'sd2000, 18'sd3000, '1 >> 6, '1,
					{16'hFFFF, 16'hFFFF, 16'hFFFF});
				default: set_config(1'($urandom), 18'(-$urandom_range(0, 3000)),
					18'($urandom_range(0, 3000)),
					{18'($urandom_range(0, 2000)), 18'($urandom_range(0, 2000)),
						18'($urandom_range(0, 1500))},
					{18'($urandom_range(5000, 131071)), 18'($urandom_range(5000, 131071)),
						18'($urandom_range(3000, 131071))},
					{16'($urandom_range(0, 600)), 16'($urandom_range(0, 600)),
						16'($urandom_range(0, 400))});
			endcase
			if (ph == 7)
				idle_on = 1'b0;
			n_items = 0;
			while (n_items < 225) begin
				frame_len = $urandom_range(1, 25);
				span = ($urandom_range(0, 3) == 0) ? 131071 : 15000;
				for (int k = 0; k < frame_len; k++) begin
					send_point(rand_coord(span), rand_coord(span),
						rand_coord($urandom_range(0, 1) ? 3000 : 131071),
						$urandom_range(0, 9) != 0, k == frame_len - 1);
					n_items++;
				end
			end
			drain();
		end

		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end
endmodule
`default_nettype wire
